// File: sv/sv39_page_table_walk_unit_defines.svh
// Assertion macros for the Sv39 page-table walk unit.
// Taken in by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SV39_PAGE_TABLE_WALK_UNIT_DEFINES_SVH
`define SV39_PAGE_TABLE_WALK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside reset
`define SV39PTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included
`define SV39PTW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SV39PTW_ASSERT(label, prop, msg)
`define SV39PTW_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: sv/sv39ptw_pkg.sv
// Shared types, codes and sizes for the Sv39 page-table walk unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package sv39ptw_pkg;

  // Table memory geometry
  localparam int TABLE_PAGES      = 8;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int STORE_WORDS      = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int ADDR_W           = $clog2(STORE_WORDS);

  // Field widths
  localparam int PPN_W   = 44;
  localparam int VA_W    = 39;
  localparam int PA_W    = 56;
  localparam int PTE_W   = 64;
  localparam int IDX_W   = 12;
  localparam int VPN_W   = 9;
  localparam int FLAGS_W = 10;
  localparam int OFF_W   = 30;
  localparam int STAT_W  = 2;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 72;

  // Request queue between front and walker
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_XLATE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ROOT = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_MAPPED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTMAP = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUTWIN = 2'd2;

  // Walk levels
  localparam logic [1:0] LVL0 = 2'd0;
  localparam logic [1:0] LVL1 = 2'd1;
  localparam logic [1:0] LVL2 = 2'd2;

  // Classified request as it sits in the queue
  typedef struct packed {
    logic              is_xlate;
    logic [ADDR_W-1:0] addr;
    logic [PTE_W-1:0]  word;
    logic [VA_W-1:0]   va;
  } ptw_cmd_t;

  // Queue head offered to the walker
  typedef struct packed {
    logic     valid;
    ptw_cmd_t cmd;
  } ptw_head_t;

  // Walker status back to the front
  typedef struct packed {
    logic clearing;
    logic pop;
  } ptw_stat_t;

  typedef enum logic [1:0] {
    WK_CLEAR,
    WK_IDLE,
    WK_LOOKUP
  } walk_state_t;

  // Nine-bit table index for a level
  function automatic logic [VPN_W-1:0] vpn_of(input logic [VA_W-1:0] va,
                                              input logic [1:0] lvl);
    logic [VPN_W-1:0] v;
    case (lvl)
      LVL2:    v = va[38:30];
      LVL1:    v = va[29:21];
      default: v = va[20:12];
    endcase
    return v;
  endfunction

  // Page offset kept from the virtual address for a leaf at a level
  function automatic logic [OFF_W-1:0] offset_of(input logic [VA_W-1:0] va,
                                                 input logic [1:0] lvl);
    logic [OFF_W-1:0] o;
    case (lvl)
      LVL2:    o = va[29:0];
      LVL1:    o = {9'd0, va[20:0]};
      default: o = {18'd0, va[11:0]};
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// File: sv/sv39ptw_front.sv
// Front end: accepts requests, classifies them and queues them for the walker.
// Depends on sv39ptw_pkg and the assertion header.
`default_nettype none
`include "sv39_page_table_walk_unit_defines.svh"

module sv39ptw_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [sv39ptw_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                              in_tuser,
  input  wire sv39ptw_pkg::ptw_stat_t            stat,
  output sv39ptw_pkg::ptw_head_t                 head
);
  import sv39ptw_pkg::*;

  ptw_cmd_t          q_mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx;
  logic              accept, in_range, push, pop;
  ptw_cmd_t          cmd;

  // Classify the incoming request
  always_comb begin
    idx          = in_tdata[11:0];
    in_range     = 32'(idx) < 32'(STORE_WORDS);
    cmd.is_xlate = (in_tuser == KIND_XLATE);
    cmd.addr     = ADDR_W'(idx);
    cmd.word     = in_tdata[75:12];
    cmd.va       = in_tdata[114:76];
  end

  // Writes past the end of the store are consumed and dropped
  assign in_tready = !stat.clearing && (cnt_r != QCNT_W'(Q_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && (cmd.is_xlate || in_range);
  assign pop       = stat.pop;

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == Q_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == Q_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_mem[rd_ptr_r];

  `SV39PTW_ASSERT(a_front_no_overfill, 32'(cnt_r) <= Q_DEPTH, "request queue overfilled")
  `SV39PTW_ASSERT(a_front_pop_nonempty, pop |-> (cnt_r != '0), "pop from an empty queue")

endmodule

`default_nettype wire

// File: sv/sv39ptw_walk.sv
// Back end: table memory with its clearing pass, configuration and the walk sequencer.
// Depends on sv39ptw_pkg and the assertion header.
`default_nettype none
`include "sv39_page_table_walk_unit_defines.svh"

module sv39ptw_walk (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic                               cfg_index,
  input  wire logic [sv39ptw_pkg::PPN_W-1:0]       cfg_wdata,
  input  wire sv39ptw_pkg::ptw_head_t             head,
  output sv39ptw_pkg::ptw_stat_t                  stat,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [sv39ptw_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import sv39ptw_pkg::*;

  walk_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [1:0]         level_r, level_nxt;
  logic [VA_W-1:0]    va_r, va_nxt;
  logic [PPN_W-1:0]   root_r, base_r;
  logic [PTE_W-1:0]   mem [STORE_WORDS];
  logic [PTE_W-1:0]   rdata_r;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r;
  logic [PA_W-1:0]    out_pa_r;
  logic [FLAGS_W-1:0] out_flags_r;

  logic               clr_done, can_emit, pop, start;
  logic [PPN_W-1:0]   cur_ppn;
  logic [VA_W-1:0]    cur_va;
  logic [1:0]         rd_level;
  logic [PPN_W:0]     diff;
  logic               win_ok;
  logic               pte_v, pte_leaf, walk_more;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [PTE_W-1:0]   mem_wdata;
  logic               res_load;
  logic [STAT_W-1:0]  res_status;
  logic [PA_W-1:0]    res_pa;
  logic [FLAGS_W-1:0] res_flags;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      base_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROOT: root_r <= cfg_wdata;
        CFG_BASE: base_r <= cfg_wdata;
        default:  root_r <= root_r;
      endcase
    end
  end

  // Table page being looked up and its place in the window
  always_comb begin
    clr_done = (clr_cnt_r == ADDR_W'(STORE_WORDS - 1));
    can_emit = !out_valid_r || out_tready;
    cur_ppn  = (state_r == WK_LOOKUP) ? rdata_r[53:10] : root_r;
    cur_va   = (state_r == WK_LOOKUP) ? va_r : head.cmd.va;
    rd_level = (state_r == WK_LOOKUP) ? level_r - 2'd1 : LVL2;
    diff     = {1'b0, cur_ppn} - {1'b0, base_r};
    win_ok   = !diff[PPN_W] && (diff[PPN_W-1:0] < PPN_W'(TABLE_PAGES));
    pte_v    = rdata_r[0];
    pte_leaf = |rdata_r[3:1];
    walk_more = pte_v && !pte_leaf && (level_r != LVL0) && win_ok;
    pop      = (state_r == WK_IDLE) && head.valid && (!head.cmd.is_xlate || can_emit);
    start    = pop && head.cmd.is_xlate && win_ok;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      WK_CLEAR:  if (clr_done) state_nxt = WK_IDLE;
      WK_IDLE:   if (start) state_nxt = WK_LOOKUP;
      WK_LOOKUP: if (!walk_more) state_nxt = WK_IDLE;
      default:   state_nxt = WK_CLEAR;
    endcase
  end

  // Memory port, sequencer registers and result selection
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = head.cmd.addr;
    mem_wdata   = head.cmd.word;
    mem_raddr   = ADDR_W'({diff[PPN_W-1:0], vpn_of(cur_va, rd_level)});
    clr_cnt_nxt = clr_cnt_r;
    level_nxt   = level_r;
    va_nxt      = va_r;
    res_load    = 1'b0;
    res_status  = ST_NOTMAP;
    res_pa      = '0;
    res_flags   = '0;
    case (state_r)
      WK_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      WK_IDLE: begin
        if (pop && !head.cmd.is_xlate) begin
          mem_we = 1'b1;
        end
        if (start) begin
          level_nxt = LVL2;
          va_nxt    = head.cmd.va;
        end
        // Root page outside the window ends the request at once
        if (pop && head.cmd.is_xlate && !win_ok) begin
          res_load   = 1'b1;
          res_status = ST_OUTWIN;
        end
      end
      WK_LOOKUP: begin
        if (walk_more) begin
          level_nxt = level_r - 2'd1;
        end else begin
          res_load = 1'b1;
          if (pte_v && pte_leaf) begin
            res_status = ST_MAPPED;
            res_pa     = {rdata_r[53:10], 12'd0} + PA_W'(offset_of(va_r, level_r));
            res_flags  = rdata_r[9:0];
          end else if (pte_v && (level_r != LVL0)) begin
            res_status = ST_OUTWIN;
          end
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = res_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= WK_CLEAR;
      clr_cnt_r   <= '0;
      level_r     <= LVL2;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    va_r <= va_nxt;
    if (res_load) begin
      out_status_r <= res_status;
      out_pa_r     <= res_pa;
      out_flags_r  <= res_flags;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign stat.clearing = (state_r == WK_CLEAR);
  assign stat.pop      = pop;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {4'd0, out_flags_r, out_pa_r, out_status_r};

  `SV39PTW_ASSERT(a_walk_slot_free, res_load |-> can_emit, "result lost: output slot busy")
  `SV39PTW_ASSERT(a_walk_no_pop_busy, (state_r != WK_IDLE) |-> !pop, "request taken mid-walk")
  `SV39PTW_ASSERT(a_walk_level, (state_r == WK_LOOKUP) |-> (level_r != 2'd3), "bad walk level")
  `SV39PTW_ASSERT(a_walk_clear_quiet, (state_r == WK_CLEAR) |-> !res_load,
                  "result produced during clearing pass")

endmodule

`default_nettype wire

// File: sv/sv39_page_table_walk_unit.sv
// Top level of the Sv39 page-table walk unit: front end, request queue and walker.
// Depends on sv39ptw_pkg, sv39ptw_front and sv39ptw_walk.
//
//  Channel  Direction  Signals                    Contents (lowest bit first)
//  in_      request    tvalid/tready/tdata/tuser  tdata: entry_index, entry_word, virt_addr
//  out_     result     tvalid/tready/tdata        tdata: status, phys_addr, leaf_flags
//  cfg_     write      wr_en/index/wdata          0 root_table_ppn, 1 window_base_ppn
//
// With the walker idle, an accepted translation leaves the queue and reads the root table,
// then examines one table level per lookup step, at most three; a root page outside the
// window answers as it leaves the queue. The single read port of the table memory and
// its registered read data set these steps. A write request updates the table memory
// as it leaves the queue. After reset the table memory is cleared, one entry a cycle,
// all STORE_WORDS (4096) entries, during which in_tready is low. A two-entry queue and the
// output register let requests be taken while a result waits on out_tready.
`default_nettype none

module sv39_page_table_walk_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // tdata: [11:0] entry_index, [75:12] entry_word, [114:76] virt_addr, rest zero
  input  wire logic [sv39ptw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: [0] kind
  input  wire logic                               in_tuser,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // tdata: [1:0] status, [57:2] phys_addr, [67:58] leaf_flags, rest zero
  output logic [sv39ptw_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_wr_en,
  input  wire logic                               cfg_index,
  input  wire logic [sv39ptw_pkg::PPN_W-1:0]       cfg_wdata
);
  import sv39ptw_pkg::*;

  ptw_head_t head;
  ptw_stat_t stat;

  sv39ptw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .head      (head)
  );

  sv39ptw_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
